// File: hdl/dbms_pkg.sv
// package: types and constants of the depth background model block
`timescale 1ns / 1ps
`default_nettype none
package dbms_pkg;

  localparam int FRAME_COLS  = 640;
  localparam int FRAME_ROWS  = 480;
  localparam int PIXEL_COUNT = FRAME_COLS * FRAME_ROWS;
  localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 19;
  localparam int DEPTH_W = 16;

  localparam logic [DEPTH_W-1:0] CAP_RESET = DEPTH_W'(5000);

  typedef enum logic [CMD_W-1:0] {
    CMD_LEARN_FIRST = 2'd0,
    CMD_LEARN_MORE  = 2'd1,
    CMD_SUBTRACT    = 2'd2
  } cmd_e;

  typedef struct packed {
    logic               write;
    logic [DEPTH_W-1:0] model;
    logic [DEPTH_W-1:0] result;
  } upd_t;

endpackage
`default_nettype wire

// File: hdl/dbms_if.sv
// interfaces: pixel input channel and result output channel
`timescale 1ns / 1ps
`default_nettype none
interface dbms_in_if;
  logic                         valid;
  logic                         ready;
  logic [dbms_pkg::CMD_W-1:0]   cmd;
  logic [dbms_pkg::IDX_W-1:0]   pixel_index;
  logic [dbms_pkg::DEPTH_W-1:0] depth_in;

  modport source (output valid, output cmd, output pixel_index, output depth_in, input ready);
  modport sink   (input valid, input cmd, input pixel_index, input depth_in, output ready);
endinterface

interface dbms_out_if;
  logic                         valid;
  logic                         ready;
  logic [dbms_pkg::DEPTH_W-1:0] depth_out;
  logic [dbms_pkg::DEPTH_W-1:0] model_value;

  modport source (output valid, output depth_out, output model_value, input ready);
  modport sink   (input valid, input depth_out, input model_value, output ready);
endinterface
`default_nettype wire

// File: hdl/dbms_ram.sv
// generic ram: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none
module dbms_ram #(
  parameter int Width = 16,
  parameter int Depth = 2,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/dbms_merge.sv
// model update: learn and subtract rules for one pixel
`timescale 1ns / 1ps
`default_nettype none
module dbms_merge (
  input  wire logic [dbms_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [dbms_pkg::DEPTH_W-1:0] depth_i,
  input  wire logic [dbms_pkg::DEPTH_W-1:0] model_i,
  input  wire logic [dbms_pkg::DEPTH_W-1:0] cap_i,
  output dbms_pkg::upd_t                    upd_o
);
  import dbms_pkg::*;

  logic [DEPTH_W-1:0] capped;
  logic               depth_zero;

  assign capped     = (depth_i < cap_i) ? depth_i : cap_i;
  assign depth_zero = (depth_i == '0);

  always_comb begin
    upd_o.write  = 1'b0;
    upd_o.model  = model_i;
    upd_o.result = '0;
    case (cmd_e'(cmd_i))
      CMD_LEARN_FIRST: begin
        upd_o.write = 1'b1;
        upd_o.model = depth_zero ? '0 : capped;
      end
      CMD_LEARN_MORE: begin
        upd_o.write = 1'b1;
        if (!depth_zero) begin
          if (model_i == '0) begin
            upd_o.model = capped;
          end else if (depth_i < model_i) begin
            upd_o.model = depth_i;
          end
        end
      end
      CMD_SUBTRACT: begin
        upd_o.result = ((model_i != '0) && (model_i <= depth_i)) ? '0 : depth_i;
      end
      default: begin
        upd_o.write = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/depth_background_min_model_subtract.sv
// top level: per-pixel minimum depth background model with subtraction
`timescale 1ns / 1ps
`default_nettype none
// Takes one pixel beat per clock and returns one result beat per pixel, in
// order, after acceptance, through the steps (memory read, model merge, output
// register). The rate of one beat per cycle is set by the frame memory, which
// does one read and one write each cycle; updates to the same pixel in
// consecutive beats are forwarded, so any pixel order runs at full rate. The
// whole pipeline holds while the output beat is not taken. The frame memory
// is not cleared at reset: a pixel must be learned with a learning command
// before it is merged or subtracted. depth_cap resets to 5000 and should only
// be written while no beats are in flight.
module depth_background_min_model_subtract (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [dbms_pkg::DEPTH_W-1:0] cfg_wdata_i,
  dbms_in_if.sink                           px_i,
  dbms_out_if.source                        res_o
);
  import dbms_pkg::*;

  logic               adv;
  logic [DEPTH_W-1:0] cap_q;
  logic               in_range;
  logic [DEPTH_W-1:0] ram_rdata;

  logic               s1_valid_q;
  logic [CMD_W-1:0]   s1_cmd_q;
  logic [ADDR_W-1:0]  s1_idx_q;
  logic               s1_range_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic [DEPTH_W-1:0] s1_model;

  logic               s2_valid_q;
  logic [CMD_W-1:0]   s2_cmd_q;
  logic [ADDR_W-1:0]  s2_idx_q;
  logic               s2_range_q;
  logic [DEPTH_W-1:0] s2_depth_q;
  logic [DEPTH_W-1:0] s2_model_q;
  upd_t               s2_upd;
  logic               s2_wr;

  logic               wb_valid_q;
  logic [ADDR_W-1:0]  wb_idx_q;
  logic [DEPTH_W-1:0] wb_model_q;

  logic               out_valid_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [DEPTH_W-1:0] out_model_q;

  assign adv        = !out_valid_q || res_o.ready;
  assign px_i.ready = adv;
  assign in_range   = (px_i.pixel_index < IDX_W'(PIXEL_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  dbms_ram #(
    .Width (DEPTH_W),
    .Depth (PIXEL_COUNT)
  ) u_model_ram (
    .clk_i   (clk_i),
    .we_i    (s2_wr),
    .waddr_i (s2_idx_q),
    .wdata_i (s2_upd.model),
    .re_i    (adv),
    .raddr_i (px_i.pixel_index[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= px_i.valid;
      s2_valid_q  <= s1_valid_q;
      wb_valid_q  <= s2_valid_q && s2_range_q && s2_upd.write;
      out_valid_q <= s2_valid_q;
    end
  end

  // forward writes not yet visible in the read data
  always_comb begin
    if (!s1_range_q) begin
      s1_model = '0;
    end else if (s2_valid_q && s2_range_q && s2_upd.write && (s2_idx_q == s1_idx_q)) begin
      s1_model = s2_upd.model;
    end else if (wb_valid_q && (wb_idx_q == s1_idx_q)) begin
      s1_model = wb_model_q;
    end else begin
      s1_model = ram_rdata;
    end
  end

  dbms_merge u_merge (
    .cmd_i   (s2_cmd_q),
    .depth_i (s2_depth_q),
    .model_i (s2_model_q),
    .cap_i   (cap_q),
    .upd_o   (s2_upd)
  );

  assign s2_wr = adv && s2_valid_q && s2_range_q && s2_upd.write;

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q    <= px_i.cmd;
      s1_idx_q    <= px_i.pixel_index[ADDR_W-1:0];
      s1_range_q  <= in_range;
      s1_depth_q  <= px_i.depth_in;
      s2_cmd_q    <= s1_cmd_q;
      s2_idx_q    <= s1_idx_q;
      s2_range_q  <= s1_range_q;
      s2_depth_q  <= s1_depth_q;
      s2_model_q  <= s1_model;
      wb_idx_q    <= s2_idx_q;
      wb_model_q  <= s2_upd.model;
      out_depth_q <= s2_upd.result;
      out_model_q <= s2_upd.model;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.depth_out   = out_depth_q;
  assign res_o.model_value = out_model_q;

endmodule
`default_nettype wire

// File: tb/sv/depth_model_monitor.sv
`timescale 1ns / 1ps
// monitor: predicts each pixel result from a shadow background model and compares result beats
module depth_model_monitor
  import dbms_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  dbms_in_if                 px_i,
  dbms_out_if                res_i,
  output int                 pending_o,
  output int                 fail_cnt_o
);

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   pixel;
    logic [DEPTH_W-1:0] depth_out;
    logic [DEPTH_W-1:0] model_value;
  } px_result_t;

  logic [DEPTH_W-1:0] depth_cap = CAP_RESET;
  logic [DEPTH_W-1:0] bg_model [int unsigned];
  px_result_t         due_results_q [$];
  px_result_t         due;
  int                 mism_cnt = 0;

  // one step of the background model, updating the shadow store
  function automatic px_result_t model_step(input logic [CMD_W-1:0] c,
                                            input logic [IDX_W-1:0] ix,
                                            input logic [DEPTH_W-1:0] d);
    px_result_t         r;
    logic [DEPTH_W-1:0] m;
    logic [DEPTH_W-1:0] capped;
    logic               in_frame;
    in_frame = (ix < PIXEL_COUNT);
    m = (in_frame && bg_model.exists(int'(ix))) ? bg_model[int'(ix)] : '0;
    capped = (d < depth_cap) ? d : depth_cap;
    r.cmd = c;
    r.pixel = ix;
    r.depth_out = '0;
    case (c)
      CMD_LEARN_FIRST: begin
        m = (d == '0) ? '0 : capped;
      end
      CMD_LEARN_MORE: begin
        if (d != '0) begin
          if (m == '0) m = capped;
          else if (d < m) m = d;
        end
      end
      CMD_SUBTRACT: begin
        r.depth_out = (m != '0 && m <= d) ? '0 : d;
      end
      default: ;
    endcase
    if (in_frame && (c == CMD_LEARN_FIRST || c == CMD_LEARN_MORE)) bg_model[int'(ix)] = m;
    r.model_value = m;
    return r;
  endfunction

  task automatic check_field(input string name, input px_result_t want,
                             input logic [DEPTH_W-1:0] exp_val,
                             input logic [DEPTH_W-1:0] got_val);
    if (got_val !== exp_val) begin
      mism_cnt++;
      if (mism_cnt <= MAX_SHOWN)
        $display("%0t: %s mismatch (cmd %0d pixel %0d): expected %0d, got %0d",
                 $time, name, want.cmd, want.pixel, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_cap = CAP_RESET;
      due_results_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) depth_cap = cfg_wdata_i;
      if (px_i.valid && px_i.ready)
        due_results_q.push_back(model_step(px_i.cmd, px_i.pixel_index, px_i.depth_in));
      if (res_i.valid && res_i.ready) begin
        if (due_results_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= MAX_SHOWN)
            $display("%0t: result beat with nothing expected: depth_out %0d model_value %0d",
                     $time, res_i.depth_out, res_i.model_value);
        end else begin
          due = due_results_q.pop_front();
          check_field("depth_out", due, due.depth_out, res_i.depth_out);
          check_field("model_value", due, due.model_value, res_i.model_value);
        end
      end
      pending_o <= due_results_q.size();
    end
    fail_cnt_o <= mism_cnt;
  end

endmodule

// File: tb/sv/depth_background_min_model_subtract_tb.sv
`timescale 1ns / 1ps
// testbench top: pixel stimulus, idling, depth cap settings and verdict for the background block
module depth_background_min_model_subtract_tb;
  import dbms_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam logic [IDX_W-1:0] LAST_PX      = IDX_W'(PIXEL_COUNT - 1);
  localparam logic [IDX_W-1:0] FIRST_OUT_PX = IDX_W'(PIXEL_COUNT);
  localparam logic [IDX_W-1:0] MAX_IDX      = '1;
  localparam int SEG_N        = 6;
  localparam int SEG_ITEMS    = 255;
  localparam int POOL_N       = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DEPTH_W-1:0] cfg_wdata_i;
  int                 pending_cnt;
  int                 fail_cnt;
  int                 cycle_cnt = 0;
  int                 src_idle_pct = 27;
  int                 snk_idle_pct = 64;
  logic [DEPTH_W-1:0] cur_cap = CAP_RESET;
  bit                 learned_px [int unsigned];
  int unsigned        px_pool [POOL_N];
  logic [IDX_W-1:0]   last_ix = '0;

  dbms_in_if  px_if ();
  dbms_out_if res_if ();

  depth_background_min_model_subtract dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .px_i        (px_if),
    .res_o       (res_if)
  );

  depth_model_monitor mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .px_i        (px_if),
    .res_i       (res_if),
    .pending_o   (pending_cnt),
    .fail_cnt_o  (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_px(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
                         input logic [DEPTH_W-1:0] d);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      px_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
    px_if.valid       <= 1'b1;
    px_if.cmd         <= c;
    px_if.pixel_index <= ix;
    px_if.depth_in    <= d;
    @(posedge clk_i);
    while (!px_if.ready) @(posedge clk_i);
    if (c == CMD_LEARN_FIRST && ix < PIXEL_COUNT) learned_px[int'(ix)] = 1'b1;
    last_ix = ix;
  endtask

  // depth half of the time in a band around the cap so that models and samples meet
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r;
    int lo;
    int hi;
    r  = $urandom_range(0, 99);
    lo = (cur_cap > 64) ? int'(cur_cap) - 64 : 0;
    hi = (cur_cap < 65471) ? int'(cur_cap) + 64 : 65535;
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 50) return DEPTH_W'($urandom_range(0, 65535));
    return DEPTH_W'($urandom_range(lo, hi));
  endfunction

  task automatic send_random();
    int               r;
    logic [IDX_W-1:0] ix;
    logic [CMD_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 15) ix = last_ix;
    else if (r < 80) ix = IDX_W'(px_pool[$urandom_range(0, POOL_N - 1)]);
    else if (r < 90) ix = IDX_W'($urandom_range(0, PIXEL_COUNT - 1));
    else ix = IDX_W'($urandom_range(PIXEL_COUNT, (1 << IDX_W) - 1));
    r = $urandom_range(0, 99);
    if (r < 15) c = CMD_LEARN_FIRST;
    else if (r < 50) c = CMD_LEARN_MORE;
    else if (r < 90) c = CMD_SUBTRACT;
    else c = CMD_UNUSED;
    // an unlearned pixel must be learned before anything reads it
    if (ix < PIXEL_COUNT && !learned_px.exists(int'(ix))) c = CMD_LEARN_FIRST;
    send_px(c, ix, pick_depth());
  endtask

  task automatic wait_drained();
    px_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_cap(input logic [DEPTH_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cap = v;
  endtask

  initial begin
    logic [DEPTH_W-1:0] cap_plan [SEG_N];
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    px_if.valid       <= 1'b0;
    px_if.cmd         <= '0;
    px_if.pixel_index <= '0;
    px_if.depth_in    <= '0;
    cap_plan[0] = '1;
    cap_plan[1] = DEPTH_W'(1);
    cap_plan[2] = '0;
    cap_plan[3] = DEPTH_W'($urandom_range(1, 65535));
    cap_plan[4] = CAP_RESET;
    cap_plan[5] = DEPTH_W'($urandom_range(1, 65535));
    px_pool[0] = 0;
    px_pool[1] = 1;
    px_pool[2] = PIXEL_COUNT - 1;
    px_pool[3] = PIXEL_COUNT - 2;
    px_pool[4] = 262144;
    px_pool[5] = FRAME_COLS;
    for (int i = 6; i < POOL_N; i++) px_pool[i] = $urandom_range(0, PIXEL_COUNT - 1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: merge rules, cap boundary, subtract boundary, unused command, off-frame pixels
    send_px(CMD_LEARN_FIRST, '0, '0);
    send_px(CMD_LEARN_MORE, '0, '0);
    send_px(CMD_LEARN_MORE, '0, '1);
    send_px(CMD_LEARN_MORE, '0, DEPTH_W'(7000));
    send_px(CMD_LEARN_MORE, '0, DEPTH_W'(1));
    send_px(CMD_SUBTRACT, '0, '0);
    send_px(CMD_SUBTRACT, '0, DEPTH_W'(1));
    send_px(CMD_SUBTRACT, '0, '1);
    send_px(CMD_LEARN_FIRST, LAST_PX, '1);
    send_px(CMD_SUBTRACT, LAST_PX, DEPTH_W'(4999));
    send_px(CMD_SUBTRACT, LAST_PX, DEPTH_W'(5000));
    send_px(CMD_UNUSED, LAST_PX, '1);
    send_px(CMD_LEARN_FIRST, IDX_W'(1), '0);
    send_px(CMD_SUBTRACT, IDX_W'(1), DEPTH_W'(1234));
    send_px(CMD_LEARN_MORE, IDX_W'(1), DEPTH_W'(4999));
    send_px(CMD_LEARN_FIRST, IDX_W'(2), DEPTH_W'(5000));
    send_px(CMD_LEARN_FIRST, IDX_W'(2), DEPTH_W'(5001));
    send_px(CMD_LEARN_FIRST, FIRST_OUT_PX, DEPTH_W'(100));
    send_px(CMD_LEARN_MORE, FIRST_OUT_PX, DEPTH_W'(300));
    send_px(CMD_SUBTRACT, MAX_IDX, '1);
    send_px(CMD_UNUSED, MAX_IDX, DEPTH_W'(16'h5555));
    send_px(CMD_SUBTRACT, FIRST_OUT_PX, '0);

    for (int seg = 0; seg < SEG_N; seg++) begin
      if (seg == 2) begin
        src_idle_pct = 64;
        snk_idle_pct = 27;
      end else if (seg == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_cap(cap_plan[seg]);
      for (int n = 0; n < SEG_ITEMS; n++) send_random();
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/dbms_pkg.sv
hdl/dbms_if.sv
hdl/dbms_ram.sv
hdl/dbms_merge.sv
hdl/depth_background_min_model_subtract.sv
tb/sv/depth_model_monitor.sv
tb/sv/depth_background_min_model_subtract_tb.sv
